>>> design/pip_pkg.sv
package pip_pkg;

    // Fixed field widths of the ports
    localparam int unsigned COORD_W = 16;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned COUNT_W = 7;

    // Function codes carried by an input word
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic write;    // store the vertex of the accepted word
        logic start;    // latch the query point, clear the count
        logic issue;    // read the next vertex slot
        logic publish;  // load the result into the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic n_zero;     // polygon in use has no vertices
        logic slot_last;  // current slot is the closing read of vertex 0
        logic pipe_busy;  // edge pipeline still holds work
    } status_t;

endpackage

>>> design/pip_ctrl.sv
module pip_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    output logic              out_valid,
    input  logic              out_ready,
    input  pip_pkg::status_t  status,
    output pip_pkg::cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.write   = accept && (func == pip_pkg::FUNC_WRITE);
        cmd.start   = accept && (func == pip_pkg::FUNC_QUERY);
        cmd.issue   = (state_reg == ST_RUN);
        cmd.publish = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = status.n_zero ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.slot_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (cmd.publish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || out_ready))
        else $error("result published over a word still waiting");
    a_empty_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && status.n_zero) |=> (state_reg == ST_DRAIN))
        else $error("empty polygon did not skip the vertex walk");
    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !status.pipe_busy)
        else $error("result stage reached with edges still in flight");
    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result word raised outside the result state");
`endif

endmodule

>>> design/pip_datapath.sv
module pip_datapath #(
    parameter int unsigned MAX_VERTICES = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pip_pkg::COUNT_W-1:0]           cfg_wdata,
    input  logic [pip_pkg::INDEX_W-1:0]           vertex_index,
    input  logic signed [pip_pkg::COORD_W-1:0]    point_x,
    input  logic signed [pip_pkg::COORD_W-1:0]    point_y,
    input  pip_pkg::cmd_t                         cmd,
    output pip_pkg::status_t                      status,
    output logic                                  inside_res,
    output logic [pip_pkg::COUNT_W-1:0]           crossing_count
);

    localparam int unsigned AW  = $clog2(MAX_VERTICES);
    localparam int unsigned CW  = $clog2(MAX_VERTICES + 1);
    localparam int unsigned NW  = (CW > pip_pkg::COUNT_W) ? CW : pip_pkg::COUNT_W;
    localparam int unsigned WIW = ((AW > pip_pkg::INDEX_W) ? AW : pip_pkg::INDEX_W) + 1;
    localparam int unsigned CWD = pip_pkg::COORD_W;
    localparam int unsigned DW  = CWD + 1;
    localparam int unsigned PW  = 2 * DW;

    // Vertex store: x in the upper half of a word, y in the lower half
    logic [2*CWD-1:0] mem [MAX_VERTICES];

    logic [pip_pkg::COUNT_W-1:0] vertex_count_reg;
    logic [NW-1:0]               vc_ext;
    logic [NW-1:0]               max_ext;
    logic [CW-1:0]               n_sat;
    logic [CW-1:0]               n_reg;
    logic [CW-1:0]               slot_reg;
    logic [CW-1:0]               slot_next;
    logic [AW-1:0]               rd_addr;
    logic [WIW-1:0]              wr_index;
    logic [AW-1:0]               wr_addr;
    logic                        wr_ok;

    logic signed [CWD-1:0] qx_reg;
    logic signed [CWD-1:0] qy_reg;

    // Read stage
    logic [2*CWD-1:0] rd_word_reg;
    logic [2*CWD-1:0] prev_word_reg;
    logic             rv_reg;
    logic             rfirst_reg;
    logic             edge_valid;

    logic signed [CWD-1:0] ax;
    logic signed [CWD-1:0] ay;
    logic signed [CWD-1:0] bx;
    logic signed [CWD-1:0] by;
    logic signed [CWD-1:0] ylo;
    logic signed [CWD-1:0] yhi;
    logic signed [CWD-1:0] xhi;

    // Difference stage
    logic                 av_reg;
    logic                 a_gate_reg;
    logic                 a_gate_next;
    logic                 a_dypos_reg;
    logic signed [DW-1:0] dx_reg;
    logic signed [DW-1:0] dy_reg;
    logic signed [DW-1:0] ex_reg;
    logic signed [DW-1:0] ey_reg;

    // Product stage
    logic                 mv_reg;
    logic                 m_gate_reg;
    logic                 m_dypos_reg;
    logic signed [PW-1:0] lhs_reg;
    logic signed [PW-1:0] rhs_reg;
    logic signed [PW-1:0] lhs_next;
    logic signed [PW-1:0] rhs_next;
    logic                 hit;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [NW-1:0] count_wide;

    // Saturate the vertex count at the store depth
    assign vc_ext  = NW'(vertex_count_reg);
    assign max_ext = NW'(MAX_VERTICES);
    assign n_sat   = (vc_ext > max_ext) ? max_ext[CW-1:0] : vc_ext[CW-1:0];

    // Slot n re-reads vertex 0 to close the polygon
    assign rd_addr  = status.slot_last ? '0 : slot_reg[AW-1:0];
    assign wr_index = WIW'(vertex_index);
    assign wr_ok    = (wr_index < WIW'(MAX_VERTICES));
    assign wr_addr  = wr_index[AW-1:0];

    assign status.n_zero    = (n_sat == '0);
    assign status.slot_last = (slot_reg == n_reg);
    assign status.pipe_busy = rv_reg || av_reg || mv_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_ok)
        begin
            mem[wr_addr] <= {point_x, point_y};
        end
        if (cmd.issue)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.start)
        begin
            slot_next = '0;
        end
        else if (cmd.issue)
        begin
            slot_next = slot_reg + CW'(1);
        end
    end

    // Edge runs from the previous word to the one just read
    assign edge_valid = rv_reg && !rfirst_reg;
    assign ax  = prev_word_reg[2*CWD-1:CWD];
    assign ay  = prev_word_reg[CWD-1:0];
    assign bx  = rd_word_reg[2*CWD-1:CWD];
    assign by  = rd_word_reg[CWD-1:0];
    assign ylo = (ay < by) ? ay : by;
    assign yhi = (ay < by) ? by : ay;
    assign xhi = (ax < bx) ? bx : ax;

    assign a_gate_next = (qy_reg > ylo) && (qy_reg <= yhi) && (qx_reg <= xhi) && (ay != by);

    assign lhs_next = ex_reg * dy_reg;
    assign rhs_next = ey_reg * dx_reg;

    assign hit = mv_reg && m_gate_reg &&
                 (m_dypos_reg ? (lhs_reg <= rhs_reg) : (lhs_reg >= rhs_reg));

    always_comb
    begin
        count_next = count_reg;
        if (cmd.start)
        begin
            count_next = '0;
        end
        else if (hit)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    assign count_wide = NW'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
            slot_reg         <= '0;
            n_reg            <= '0;
            rv_reg           <= 1'b0;
            rfirst_reg       <= 1'b0;
            av_reg           <= 1'b0;
            mv_reg           <= 1'b0;
            count_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                vertex_count_reg <= cfg_wdata;
            end
            if (cmd.start)
            begin
                n_reg <= n_sat;
            end
            slot_reg   <= slot_next;
            rv_reg     <= cmd.issue;
            rfirst_reg <= cmd.issue && (slot_reg == '0);
            av_reg     <= edge_valid;
            mv_reg     <= av_reg;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            qx_reg <= point_x;
            qy_reg <= point_y;
        end
        if (rv_reg)
        begin
            prev_word_reg <= rd_word_reg;
        end
        a_gate_reg  <= a_gate_next;
        a_dypos_reg <= (by > ay);
        dx_reg      <= DW'(bx) - DW'(ax);
        dy_reg      <= DW'(by) - DW'(ay);
        ex_reg      <= DW'(qx_reg) - DW'(ax);
        ey_reg      <= DW'(qy_reg) - DW'(ay);
        m_gate_reg  <= a_gate_reg;
        m_dypos_reg <= a_dypos_reg;
        lhs_reg     <= lhs_next;
        rhs_reg     <= rhs_next;
        if (cmd.publish)
        begin
            inside_res     <= count_reg[0];
            crossing_count <= count_wide[pip_pkg::COUNT_W-1:0];
        end
    end

`ifndef SYNTHESIS
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (slot_reg <= n_reg))
        else $error("vertex read beyond the closing slot");
    a_no_read_on_publish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!rv_reg && !av_reg && !mv_reg))
        else $error("count published before the edge pipeline drained");
`endif

endmodule

>>> design/point_in_polygon_test.sv
// Even-odd point-in-polygon test on signed Q8.8 coordinates.
// Input channel (in_valid/in_ready) carries one word: func selects a vertex
// write (vertex_index, point_x, point_y stored) or a point query.
// A write gives no result word. Writes to an index at or
// above MAX_VERTICES are dropped.
// A query walks the first n vertices (n = vertex_count saturated at
// MAX_VERTICES) plus a closing re-read of vertex 0, one memory read per cycle,
// through a three-stage edge pipeline (differences, cross products, compare).
// An empty polygon skips the walk. The next word is taken only after the
// result is loaded into the output register, so queries do not overlap;
// the walk over the single read port of the vertex memory sets the query
// rate.
// Output channel (out_valid/out_ready) carries inside_res and crossing_count
// from an output register: a waiting result does not stop the next word
// being accepted, but a finished query holds until that register is free.
// cfg_we writes vertex_count; write it only while idle.
// Reset clears the state machine, the output valid and vertex_count; the
// vertex memory is not cleared, so vertices must be written before use.
module point_in_polygon_test #(
    parameter int unsigned MAX_VERTICES = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  func,
    input  logic [pip_pkg::INDEX_W-1:0]           vertex_index,
    input  logic signed [pip_pkg::COORD_W-1:0]    point_x,
    input  logic signed [pip_pkg::COORD_W-1:0]    point_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  inside_res,
    output logic [pip_pkg::COUNT_W-1:0]           crossing_count,
    input  logic                                  cfg_we,
    input  logic [pip_pkg::COUNT_W-1:0]           cfg_wdata
);

    pip_pkg::cmd_t    cmd;
    pip_pkg::status_t status;

    // Sequence the walk: accept, read slots, drain, publish
    pip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the vertices and test one edge per cycle
    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .vertex_index   (vertex_index),
        .point_x        (point_x),
        .point_y        (point_y),
        .cmd            (cmd),
        .status         (status),
        .inside_res     (inside_res),
        .crossing_count (crossing_count)
    );

endmodule
